### sv/assert_macros.svh
// assertion macros used by the mapper rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("mapper assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("mapper forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

### sv/cbm_pkg.sv
// shared types, codes and helpers of the cartridge bank mapper
package cbm_pkg;

   // access kinds
   localparam logic [1:0] KIND_CPU_READ  = 2'd0;
   localparam logic [1:0] KIND_CPU_WRITE = 2'd1;
   localparam logic [1:0] KIND_PPU_READ  = 2'd2;
   localparam logic [1:0] KIND_PPU_WRITE = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_PRG_BANK_COUNT = 2'd0;
   localparam logic [1:0] CSR_CHR_BANK_COUNT = 2'd1;
   localparam logic [1:0] CSR_CHR_IS_RAM     = 2'd2;

   // cpu address regions (address bits 15:13)
   localparam logic [2:0] REGION_BANK   = 3'd4;
   localparam logic [2:0] REGION_MIRROR = 3'd5;

   localparam logic [6:0] PRG_COUNT_RESET = 7'd2;
   localparam logic [8:0] CHR_COUNT_RESET = 9'd8;
   localparam logic [6:0] PRG_COUNT_MIN   = 7'd2;
   localparam logic [6:0] PRG_COUNT_MAX   = 7'd64;
   localparam logic [8:0] CHR_COUNT_MIN   = 9'd1;
   localparam logic [8:0] CHR_COUNT_MAX   = 9'd256;

   localparam logic [2:0] BANK_REG_R6 = 3'd6;
   localparam logic [2:0] BANK_REG_R7 = 3'd7;

   typedef struct packed {
      logic       start;
      logic [7:0] dividend;
      logic [8:0] divisor;
   } mod_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_sts_type;

   typedef struct packed {
      logic prg_swap;
      logic chr_swap;
      logic mirroring;
   } mode_type;

   function automatic logic [6:0] prg_count_sat(input logic [6:0] n);
      logic [6:0] r;
      r = n;
      if (n < PRG_COUNT_MIN) r = PRG_COUNT_MIN;
      if (n > PRG_COUNT_MAX) r = PRG_COUNT_MAX;
      return r;
   endfunction

   function automatic logic [8:0] chr_count_sat(input logic [8:0] n);
      logic [8:0] r;
      r = n;
      if (n < CHR_COUNT_MIN) r = CHR_COUNT_MIN;
      if (n > CHR_COUNT_MAX) r = CHR_COUNT_MAX;
      return r;
   endfunction

endpackage

### sv/cbm_mod_unit.sv
// iterative remainder unit: one dividend bit per cycle, restoring form
module cbm_mod_unit (
   input  logic                clock,
   input  logic                reset,
   input  cbm_pkg::mod_ctl_type ctl,
   output cbm_pkg::mod_sts_type sts,
   output logic [7:0]          remainder
);

   logic [7:0] rem_ff, rem_in;
   logic [7:0] dvd_ff, dvd_in;
   logic [8:0] div_ff, div_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       run_ff, run_in;
   logic       done_ff, done_in;
   logic [8:0] shifted;
   logic [8:0] diff;

   always_comb begin
      shifted = {rem_ff, dvd_ff[7]};
      diff    = shifted - div_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         rem_in = '0;
         dvd_in = ctl.dividend;
         div_in = ctl.divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         // remainder stays below the divisor, at most 255
         rem_in = (shifted >= div_ff) ? diff[7:0] : shifted[7:0];
         dvd_in = {dvd_ff[6:0], 1'b0};
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
   end

   assign sts.busy  = run_ff;
   assign sts.done  = done_ff;
   assign remainder = rem_ff;

endmodule

### sv/cbm_bank_file.sv
// mapper register file: bank select, mode bits, eight bank registers, mirroring
module cbm_bank_file (
   input  logic             clock,
   input  logic             reset,
   input  logic             upd_en,
   input  logic [15:0]      upd_address,
   input  logic [7:0]       upd_data,
   input  logic [2:0]       rd_index,
   output logic [7:0]       rd_data,
   output cbm_pkg::mode_type mode
);

   logic [7:0] bank_ff [8];
   logic [2:0] sel_ff;
   logic       prg_swap_ff;
   logic       chr_swap_ff;
   logic       mirror_ff;
   logic       bank_hit;
   logic       mirror_hit;

   assign bank_hit   = upd_en && (upd_address[15:13] == cbm_pkg::REGION_BANK);
   assign mirror_hit = upd_en && (upd_address[15:13] == cbm_pkg::REGION_MIRROR)
                       && !upd_address[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff      <= '0;
         prg_swap_ff <= 1'b0;
         chr_swap_ff <= 1'b0;
         mirror_ff   <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            bank_ff[i] <= '0;
         end
      end else begin
         if (bank_hit) begin
            if (!upd_address[0]) begin
               sel_ff      <= upd_data[2:0];
               prg_swap_ff <= upd_data[6];
               chr_swap_ff <= upd_data[7];
            end else begin
               bank_ff[sel_ff] <= upd_data;
            end
         end
         if (mirror_hit) begin
            mirror_ff <= upd_data[0];
         end
      end
   end

   assign rd_data        = bank_ff[rd_index];
   assign mode.prg_swap  = prg_swap_ff;
   assign mode.chr_swap  = chr_swap_ff;
   assign mode.mirroring = mirror_ff;

endmodule

### sv/cartridge_bank_mapper_core.sv
// Bank-switching address translator for a game cartridge (no scanline irq). Each request
// is one cpu or ppu bus access; each gives exactly one response carrying the
// physical program or character address, or no access for register writes,
// unmapped cpu reads and ppu writes to character rom. Mapped reads and
// character ram writes reduce the bank number modulo the bank count in a
// shared one-bit-per-cycle remainder unit of 8 iterations; register writes
// and other accesses needing no bank bypass it. The response sits in an
// output register, so the next request is taken while it waits.
// Configuration writes are always taken, and must only be issued while no
// request is in flight.
`include "assert_macros.svh"

module cartridge_bank_mapper_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_access_valid,
   output logic        rsp_is_write,
   output logic        rsp_memory_select,
   output logic [18:0] rsp_phys_address,
   output logic [7:0]  rsp_write_data,
   output logic        rsp_mirroring
);

   typedef enum logic [1:0] {S_IDLE, S_WAIT, S_EMIT} state_type;

   state_type state_ff;
   logic [6:0]  prg_cfg_ff;
   logic [8:0]  chr_cfg_ff;
   logic        chr_ram_ff;
   logic [1:0]  kind_ff;
   logic [15:0] addr_ff;
   logic [7:0]  data_ff;
   logic        rsp_valid_ff;
   logic        rsp_access_ff;
   logic        rsp_write_ff;
   logic        rsp_sel_ff;
   logic [18:0] rsp_phys_ff;
   logic [7:0]  rsp_wdata_ff;
   logic        rsp_mirror_ff;

   cbm_pkg::mod_ctl_type mod_ctl;
   cbm_pkg::mod_sts_type mod_sts;
   cbm_pkg::mode_type    mode;
   logic [7:0]  remainder;
   logic        req_xfer;
   logic        emit_go;
   logic        need_mod;
   logic [6:0]  prg_n;
   logic [8:0]  chr_n;
   logic [2:0]  slot;
   logic [2:0]  rd_index;
   logic [7:0]  rd_data;
   logic [7:0]  chr_raw;
   logic [6:0]  prg_last;
   logic [6:0]  prg_last_m1;
   logic [5:0]  prg_bank;
   logic        res_access;
   logic        res_write;
   logic        res_sel;
   logic [18:0] res_phys;
   logic [7:0]  res_wdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_cfg_ff <= cbm_pkg::PRG_COUNT_RESET;
         chr_cfg_ff <= cbm_pkg::CHR_COUNT_RESET;
         chr_ram_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cbm_pkg::CSR_PRG_BANK_COUNT: prg_cfg_ff <= csr_data[6:0];
            cbm_pkg::CSR_CHR_BANK_COUNT: chr_cfg_ff <= csr_data;
            cbm_pkg::CSR_CHR_IS_RAM:     chr_ram_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign prg_n    = cbm_pkg::prg_count_sat(prg_cfg_ff);
   assign chr_n    = cbm_pkg::chr_count_sat(chr_cfg_ff);
   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;

   // character slot, swapped halves in chr mode 1
   assign slot    = req_address[12:10] ^ {mode.chr_swap, 2'b00};
   assign chr_raw = slot[2] ? rd_data : {rd_data[7:1], slot[0]};

   always_comb begin
      if (req_kind == cbm_pkg::KIND_CPU_READ) begin
         rd_index = (req_address[14:13] == 2'b01) ? cbm_pkg::BANK_REG_R7
                                                  : cbm_pkg::BANK_REG_R6;
      end else if (slot[2]) begin
         rd_index = slot - 3'd2;
      end else begin
         rd_index = {2'b00, slot[1]};
      end
   end

   always_comb begin
      need_mod = 1'b0;
      case (req_kind)
         cbm_pkg::KIND_CPU_READ:  need_mod = req_address[15];
         cbm_pkg::KIND_PPU_READ:  need_mod = 1'b1;
         cbm_pkg::KIND_PPU_WRITE: need_mod = chr_ram_ff;
         default:                 need_mod = 1'b0;
      endcase
   end

   always_comb begin
      mod_ctl.start = req_xfer && need_mod;
      if (req_kind == cbm_pkg::KIND_CPU_READ) begin
         mod_ctl.dividend = rd_data;
         mod_ctl.divisor  = {2'b00, prg_n};
      end else begin
         mod_ctl.dividend = chr_raw;
         mod_ctl.divisor  = chr_n;
      end
   end

   cbm_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mod_ctl),
      .sts       (mod_sts),
      .remainder (remainder)
   );

   cbm_bank_file u_banks (
      .clock       (clock),
      .reset       (reset),
      .upd_en      (req_xfer && (req_kind == cbm_pkg::KIND_CPU_WRITE)),
      .upd_address (req_address),
      .upd_data    (req_data),
      .rd_index    (rd_index),
      .rd_data     (rd_data),
      .mode        (mode)
   );

   assign prg_last    = prg_n - 7'd1;
   assign prg_last_m1 = prg_n - 7'd2;

   always_comb begin
      unique case (addr_ff[14:13])
         2'b00:   prg_bank = mode.prg_swap ? prg_last_m1[5:0] : remainder[5:0];
         2'b01:   prg_bank = remainder[5:0];
         2'b10:   prg_bank = mode.prg_swap ? remainder[5:0] : prg_last_m1[5:0];
         default: prg_bank = prg_last[5:0];
      endcase
   end

   always_comb begin
      res_access = 1'b0;
      res_write  = 1'b0;
      res_sel    = 1'b0;
      res_phys   = '0;
      res_wdata  = '0;
      unique case (kind_ff)
         cbm_pkg::KIND_CPU_READ: begin
            if (addr_ff[15]) begin
               res_access = 1'b1;
               res_phys   = {prg_bank, addr_ff[12:0]};
            end
         end
         cbm_pkg::KIND_CPU_WRITE: ;
         cbm_pkg::KIND_PPU_READ: begin
            res_access = 1'b1;
            res_sel    = 1'b1;
            res_phys   = {1'b0, remainder, addr_ff[9:0]};
         end
         cbm_pkg::KIND_PPU_WRITE: begin
            if (chr_ram_ff) begin
               res_access = 1'b1;
               res_sel    = 1'b1;
               res_write  = 1'b1;
               res_phys   = {1'b0, remainder, addr_ff[9:0]};
               res_wdata  = data_ff;
            end
         end
         default: ;
      endcase
   end

   assign emit_go = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  state_ff <= need_mod ? S_WAIT : S_EMIT;
               end
            end
            S_WAIT: begin
               if (mod_sts.done) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (emit_go) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
      if (req_xfer) begin
         kind_ff <= req_kind;
         addr_ff <= req_address;
         data_ff <= req_data;
      end
      if (emit_go) begin
         rsp_access_ff <= res_access;
         rsp_write_ff  <= res_write;
         rsp_sel_ff    <= res_sel;
         rsp_phys_ff   <= res_phys;
         rsp_wdata_ff  <= res_wdata;
         rsp_mirror_ff <= mode.mirroring;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_access_valid  = rsp_access_ff;
   assign rsp_is_write      = rsp_write_ff;
   assign rsp_memory_select = rsp_sel_ff;
   assign rsp_phys_address  = rsp_phys_ff;
   assign rsp_write_data    = rsp_wdata_ff;
   assign rsp_mirroring     = rsp_mirror_ff;

   // the remainder unit only runs while the sequencer waits on it
   `ASSERT_PROP(a_busy_not_idle, clock, reset, mod_sts.busy |-> (state_ff == S_WAIT))
   `ASSERT_PROP(a_done_in_wait, clock, reset, mod_sts.done |-> (state_ff == S_WAIT))
   // no access means an all-zero payload
   `ASSERT_PROP(a_noaccess_zero, clock, reset,
      (rsp_valid_ff && !rsp_access_ff) |-> (rsp_phys_ff == '0 && rsp_wdata_ff == '0))
   `ASSERT_NEVER(a_write_to_prg, clock, reset, rsp_valid_ff && rsp_write_ff && !rsp_sel_ff)

endmodule

### tb/tb_cartridge_bank_mapper_core.sv
// testbench for the cartridge bank mapper core: directed and random accesses vs a predictor
module tb_cartridge_bank_mapper_core;

   localparam logic [2:0] REGION_SWITCH = 3'd6;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_ACCESSES = 235;

   typedef struct packed {
      logic        access_valid;
      logic        is_write;
      logic        memory_select;
      logic [18:0] phys_address;
      logic [7:0]  write_data;
      logic        mirroring;
   } map_result_type;

   class bank_map_checker;
      logic [6:0]  prg_count_raw;
      logic [8:0]  chr_count_raw;
      logic        chr_ram;
      logic [2:0]  sel_reg;
      logic        prg_swap;
      logic        chr_swap;
      logic        mirror;
      logic [7:0]  bank_reg [8];
      map_result_type expected_maps [$];
      int unsigned failures;

      function new();
         prg_count_raw = cbm_pkg::PRG_COUNT_RESET;
         chr_count_raw = cbm_pkg::CHR_COUNT_RESET;
         chr_ram = 1'b0;
         sel_reg = 3'd0;
         prg_swap = 1'b0;
         chr_swap = 1'b0;
         mirror = 1'b0;
         foreach (bank_reg[i]) bank_reg[i] = 8'd0;
         failures = 0;
      endfunction

      function void write_register(input logic [1:0] idx, input logic [8:0] value);
         case (idx)
            cbm_pkg::CSR_PRG_BANK_COUNT: prg_count_raw = value[6:0];
            cbm_pkg::CSR_CHR_BANK_COUNT: chr_count_raw = value;
            cbm_pkg::CSR_CHR_IS_RAM: chr_ram = value[0];
            default: ;
         endcase
      endfunction

      // 8 KiB program bank for a cpu address at 0x8000 and above
      function int unsigned prg_bank(input logic [15:0] addr);
         int unsigned n;
         int unsigned last;
         int unsigned bank;
         n = prg_count_raw;
         if (n < cbm_pkg::PRG_COUNT_MIN) n = cbm_pkg::PRG_COUNT_MIN;
         if (n > cbm_pkg::PRG_COUNT_MAX) n = cbm_pkg::PRG_COUNT_MAX;
         last = n - 1;
         case (addr[15:13])
            cbm_pkg::REGION_BANK:
               bank = prg_swap ? last - 1 : bank_reg[cbm_pkg::BANK_REG_R6] % n;
            cbm_pkg::REGION_MIRROR: bank = bank_reg[cbm_pkg::BANK_REG_R7] % n;
            REGION_SWITCH:
               bank = prg_swap ? bank_reg[cbm_pkg::BANK_REG_R6] % n : last - 1;
            default: bank = last;
         endcase
         return bank;
      endfunction

      // 1 KiB character bank; each 2 KiB slot takes an even/odd bank pair from one register
      function int unsigned chr_bank(input logic [12:0] addr);
         logic [2:0]  slot;
         int unsigned raw;
         int unsigned n;
         slot = addr[12:10] ^ {chr_swap, 2'b00};
         if (!slot[2]) raw = {bank_reg[slot[1]][7:1], slot[0]};
         else raw = bank_reg[slot - 3'd2];
         n = chr_count_raw;
         if (n < cbm_pkg::CHR_COUNT_MIN) n = cbm_pkg::CHR_COUNT_MIN;
         if (n > cbm_pkg::CHR_COUNT_MAX) n = cbm_pkg::CHR_COUNT_MAX;
         return raw % n;
      endfunction

      function map_result_type translate_access(input logic [1:0] kind,
                                                input logic [15:0] addr,
                                                input logic [7:0] data);
         map_result_type r;
         r = '0;
         case (kind)
            cbm_pkg::KIND_CPU_READ: begin
               if (addr[15]) begin
                  r.access_valid = 1'b1;
                  r.phys_address = 19'((prg_bank(addr) << 13) | addr[12:0]);
               end
            end
            cbm_pkg::KIND_CPU_WRITE: begin
               if (addr[15:13] == cbm_pkg::REGION_BANK) begin
                  if (!addr[0]) begin
                     sel_reg = data[2:0];
                     prg_swap = data[6];
                     chr_swap = data[7];
                  end else begin
                     bank_reg[sel_reg] = data;
                  end
               end else if (addr[15:13] == cbm_pkg::REGION_MIRROR && !addr[0]) begin
                  mirror = data[0];
               end
            end
            default: begin
               // ppu side: writes to character rom are dropped
               if (kind == cbm_pkg::KIND_PPU_READ || chr_ram) begin
                  r.access_valid = 1'b1;
                  r.memory_select = 1'b1;
                  r.phys_address = 19'((chr_bank(addr[12:0]) << 10) | addr[9:0]);
                  if (kind == cbm_pkg::KIND_PPU_WRITE) begin
                     r.is_write = 1'b1;
                     r.write_data = data;
                  end
               end
            end
         endcase
         r.mirroring = mirror;
         return r;
      endfunction

      function void note_access(input logic [1:0] kind, input logic [15:0] addr,
                                input logic [7:0] data);
         expected_maps.push_back(translate_access(kind, addr, data));
      endfunction

      function void check_mapping(input map_result_type got);
         map_result_type want;
         if (expected_maps.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("response with no access pending: phys %05h valid %0b",
                        got.phys_address, got.access_valid);
            return;
         end
         want = expected_maps.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= 10) begin
               $display("mismatch (expected/actual): valid %0b/%0b write %0b/%0b sel %0b/%0b",
                        want.access_valid, got.access_valid, want.is_write, got.is_write,
                        want.memory_select, got.memory_select);
               $display("   phys %05h/%05h wdata %02h/%02h mirroring %0b/%0b",
                        want.phys_address, got.phys_address, want.write_data, got.write_data,
                        want.mirroring, got.mirroring);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [8:0]  csr_data;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_kind;
   logic [15:0] req_address;
   logic [7:0]  req_data;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_access_valid;
   logic        rsp_is_write;
   logic        rsp_memory_select;
   logic [18:0] rsp_phys_address;
   logic [7:0]  rsp_write_data;
   logic        rsp_mirroring;

   bank_map_checker chk;
   int burst_left = 0;
   int gap_max = 4;
   int stall_mode = 1;
   int stall_left = 0;
   int accesses_sent = 0;
   int quiet_cycles = 0;

   cartridge_bank_mapper_core uut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_address(req_address),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_access_valid(rsp_access_valid),
      .rsp_is_write(rsp_is_write),
      .rsp_memory_select(rsp_memory_select),
      .rsp_phys_address(rsp_phys_address),
      .rsp_write_data(rsp_write_data),
      .rsp_mirroring(rsp_mirroring)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // response side stalls in short random runs, harder as stall_mode rises
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (stall_mode != 0 && $urandom_range(0, 7) < stall_mode * 2) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 6);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) chk.write_register(csr_index, csr_data);
         if (req_valid && req_ready) chk.note_access(req_kind, req_address, req_data);
         if (rsp_valid && rsp_ready)
            chk.check_mapping({rsp_access_valid, rsp_is_write, rsp_memory_select,
                               rsp_phys_address, rsp_write_data, rsp_mirroring});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [1:0] kind, input logic [15:0] addr,
                            input logic [7:0] data);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_kind <= kind;
      req_address <= addr;
      req_data <= data;
      do @(posedge clock); while (!req_ready);
      accesses_sent++;
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [8:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [8:0] prg, input logic [8:0] chr, input logic ram);
      write_csr(cbm_pkg::CSR_PRG_BANK_COUNT, prg);
      write_csr(cbm_pkg::CSR_CHR_BANK_COUNT, chr);
      write_csr(cbm_pkg::CSR_CHR_IS_RAM, {8'd0, ram});
      csr_valid <= 1'b0;
   endtask

   // hold off the sender until every response is back and the core has settled
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (chk.expected_maps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_random_access();
      int pick;
      logic [11:0] mid;
      pick = $urandom_range(0, 99);
      mid = 12'($urandom);
      if (pick < 30) begin
         if ($urandom_range(0, 9) == 0)
            send_item(cbm_pkg::KIND_CPU_READ, 16'($urandom_range(0, 16'h7FFF)),
                      8'($urandom));
         else
            send_item(cbm_pkg::KIND_CPU_READ, 16'($urandom_range(16'h8000, 16'hFFFF)),
                      8'($urandom));
      end else if (pick < 55) begin
         // bank select followed by its data transfer
         send_item(cbm_pkg::KIND_CPU_WRITE, {cbm_pkg::REGION_BANK, mid, 1'b0},
                   8'($urandom));
         send_item(cbm_pkg::KIND_CPU_WRITE, {cbm_pkg::REGION_BANK, 12'($urandom), 1'b1},
                   8'($urandom));
      end else if (pick < 61) begin
         send_item(cbm_pkg::KIND_CPU_WRITE,
                   {cbm_pkg::REGION_MIRROR, mid, 1'($urandom_range(0, 3) == 0)},
                   8'($urandom));
      end else if (pick < 66) begin
         send_item(cbm_pkg::KIND_CPU_WRITE, 16'($urandom), 8'($urandom));
      end else if (pick < 84) begin
         send_item(cbm_pkg::KIND_PPU_READ, 16'($urandom), 8'($urandom));
      end else begin
         send_item(cbm_pkg::KIND_PPU_WRITE, 16'($urandom), 8'($urandom));
      end
   endtask

   initial begin : stimulus
      int phase;
      chk = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_kind <= cbm_pkg::KIND_CPU_READ;
      req_address <= 16'd0;
      req_data <= 8'd0;
      csr_valid <= 1'b0;
      csr_index <= cbm_pkg::CSR_PRG_BANK_COUNT;
      csr_data <= 9'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // unmapped reads, then each program window at reset
      send_item(cbm_pkg::KIND_CPU_READ, 16'h0000, 8'hFF);
      send_item(cbm_pkg::KIND_CPU_READ, 16'h7FFF, 8'h00);
      send_item(cbm_pkg::KIND_CPU_READ, 16'h8000, 8'h00);
      send_item(cbm_pkg::KIND_CPU_READ, 16'hBFFF, 8'h00);
      send_item(cbm_pkg::KIND_CPU_READ, 16'hC000, 8'h00);
      send_item(cbm_pkg::KIND_CPU_READ, 16'hFFFF, 8'h00);
      // r7 with both swap modes, then r6 with program swap only
      send_item(cbm_pkg::KIND_CPU_WRITE, 16'h8000, 8'hC7);
      send_item(cbm_pkg::KIND_CPU_WRITE, 16'h9FFF, 8'hFF);
      send_item(cbm_pkg::KIND_CPU_WRITE, 16'h9FFE, 8'h46);
      send_item(cbm_pkg::KIND_CPU_WRITE, 16'h8001, 8'h85);
      // mirroring set, then writes that must be ignored
      send_item(cbm_pkg::KIND_CPU_WRITE, 16'hA000, 8'h01);
      send_item(cbm_pkg::KIND_CPU_WRITE, 16'hA001, 8'h00);
      send_item(cbm_pkg::KIND_CPU_WRITE, 16'hC000, 8'h00);
      send_item(cbm_pkg::KIND_CPU_WRITE, 16'h7FFE, 8'h01);
      send_item(cbm_pkg::KIND_CPU_READ, 16'h9FFF, 8'h00);
      send_item(cbm_pkg::KIND_CPU_READ, 16'hA000, 8'h00);
      send_item(cbm_pkg::KIND_CPU_READ, 16'hDFFF, 8'h00);
      // ppu accesses, upper address bits ignored, write to rom dropped
      send_item(cbm_pkg::KIND_PPU_READ, 16'h0000, 8'h00);
      send_item(cbm_pkg::KIND_PPU_READ, 16'hFFFF, 8'h00);
      send_item(cbm_pkg::KIND_PPU_WRITE, 16'h1234, 8'hAA);
      wait_idle();

      // counts below and above range, character ram
      configure(9'h1FF, 9'd0, 1'b1);
      send_item(cbm_pkg::KIND_PPU_WRITE, 16'hE3FF, 8'hFF);
      send_item(cbm_pkg::KIND_PPU_WRITE, 16'h0000, 8'h00);
      send_item(cbm_pkg::KIND_CPU_READ, 16'hE000, 8'h00);
      wait_idle();
      configure(9'd0, 9'h1FF, 1'b0);
      send_item(cbm_pkg::KIND_CPU_READ, 16'hC000, 8'h00);
      send_item(cbm_pkg::KIND_PPU_READ, 16'h17FF, 8'h00);
      wait_idle();

      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: configure(9'd2, 9'd1, 1'b0);
            1: configure(9'd64, 9'd256, 1'b1);
            2: configure(9'd0, 9'd0, 1'b1);
            3: configure(9'h1FF, 9'h1FF, 1'b0);
            4: configure(9'd1, 9'd257, 1'b1);
            default: configure(phase[0] ? 9'($urandom_range(2, 64)) : 9'($urandom),
                               9'($urandom_range(1, 300)), 1'($urandom));
         endcase
         stall_mode = phase % 3;
         gap_max = (phase % 3 == 0) ? 0 : $urandom_range(3, 10);
         accesses_sent = 0;
         while (accesses_sent < PHASE_ACCESSES) send_random_access();
         wait_idle();
      end

      if (chk.failures == 0 && chk.expected_maps.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
